// ===== rtl/vsrm_pkg.sv =====
`default_nettype none
package vsrm_pkg;
   localparam int STEP_FRAC = 14;

   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_RASTER = 2'd1,
      CMD_RAY    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ABSORBED = 2'd0,
      ST_VERTICAL = 2'd1,
      ST_NEIGHBOUR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_STEP_X = 2'd0,
      CSR_STEP_Y = 2'd1,
      CSR_STEP_Z = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RMW_RD,
      S_RMW_WR,
      S_RAY_CHK,
      S_RAY_RD,
      S_RAY_SUB,
      S_DONE
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) return 16'sh7fff;
      if (v < -40'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/voxel_shadow_ray_march.sv =====
`default_nettype none
// voxel_shadow_ray_march
// requests enter on req_valid/req_stall; cast-ray requests give one result on
// rsp_valid/rsp_stall, begin and raster requests give none.
// after reset the grid memory is cleared, one cell a cycle, over all
// GRID_XY*GRID_XY*GRID_Z cells (13312 by default); req_stall is high meanwhile.
// configuration is written through csr_write/csr_index/csr_data; the user must
// write it only while idle, the block itself does not enforce it.
// a raster byte is read, added and written back; a ray marches up to
// 2*(2*GRID_XY+MARCH_Z_LIMIT) cells, each step waiting on the memory read.
// the result sits in an output register until taken; until then the block
// takes no new request.
module voxel_shadow_ray_march
   import vsrm_pkg::*;
#(
   parameter int GRID_XY = 16,
   parameter int GRID_Z = 52,
   parameter int MARCH_Z_LIMIT = 45,
   parameter int FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_pos_z,
   input  wire logic signed [6:0]  req_offset_x,
   input  wire logic signed [6:0]  req_offset_y,
   input  wire logic signed [6:0]  req_offset_z,
   input  wire logic [6:0]         req_extent_x,
   input  wire logic [6:0]         req_extent_y,
   input  wire logic [6:0]         req_extent_z,
   input  wire logic signed [15:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_intensity_left,
   output logic [1:0]              rsp_status,
   output logic signed [1:0]       rsp_neighbour_dx,
   output logic signed [1:0]       rsp_neighbour_dy,
   output logic signed [15:0]      rsp_exit_x,
   output logic signed [15:0]      rsp_exit_y,
   output logic signed [15:0]      rsp_exit_z,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   localparam int CELLS = GRID_XY * GRID_XY * GRID_Z;
   localparam int AW = $clog2(CELLS);
   localparam int MAX_STEPS = 2 * (2 * GRID_XY + MARCH_Z_LIMIT);
   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam int UP = STEP_FRAC - FRAC_BITS;
   localparam logic signed [31:0] XY_LIM = GRID_XY * (32'sd1 <<< STEP_FRAC);
   localparam logic signed [31:0] Z_LIM = MARCH_Z_LIMIT * (32'sd1 <<< STEP_FRAC);
   localparam logic [31:0] DIV5_K18 = 32'd52429;
   localparam logic [55:0] DIV5_K29 = 56'd107374183;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic signed [15:0] stx_ff, sty_ff, stz_ff;
   logic signed [15:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [6:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [6:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [7:0] byte_ff, byte_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [31:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic signed [23:0] inten_ff, inten_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic rv_ff, rv_in;
   logic signed [15:0] ri_ff, ri_in, ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic [1:0] rs_ff, rs_in;
   logic signed [1:0] ndx_ff, ndx_in, ndy_ff, ndy_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   vsrm_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic accept;
   logic signed [15:0] tx, ty, tz, nx, ny, nz;
   logic signed [31:0] gz0;
   logic in_grid, in_z;
   logic signed [31:0] zc;
   logic [8:0] sum9;
   logic signed [31:0] ax, ay;
   logic signed [35:0] ez5;
   logic signed [31:0] bt;
   logic [15:0] bt_mag;
   logic [31:0] bt_prod;
   logic signed [15:0] bz_div;
   logic [27:0] gz_mag;
   logic [55:0] gz_prod;
   logic signed [31:0] gz_div;
   logic signed [23:0] inten_sub;

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_intensity_left = ri_ff;
   assign rsp_status = rs_ff;
   assign rsp_neighbour_dx = ndx_ff;
   assign rsp_neighbour_dy = ndy_ff;
   assign rsp_exit_x = ex_ff;
   assign rsp_exit_y = ey_ff;
   assign rsp_exit_z = ez_ff;

   always_comb begin
      tx = req_pos_x >>> FRAC_BITS;
      ty = req_pos_y >>> FRAC_BITS;
      tz = req_pos_z >>> FRAC_BITS;
      nx = bx_ff + 16'(signed'({1'b0, cx_ff}));
      ny = by_ff + 16'(signed'({1'b0, cy_ff}));
      nz = bz_ff + 16'(signed'({1'b0, cz_ff}));
      // tile z plus 128, divided by 5, truncating toward zero
      bt = 32'(tz) + 32'sd128;
      bt_mag = (bt < 0) ? 16'(-bt) : 16'(bt);
      bt_prod = 32'(bt_mag) * DIV5_K18;
      bz_div = (bt < 0) ? -16'(bt_prod[31:18]) : 16'(bt_prod[31:18]);
      // grid z divided by 5, rounding toward minus infinity
      gz0 = (32'(req_pos_z) + (32'sd128 <<< FRAC_BITS)) <<< UP;
      gz_mag = (gz0 < 0) ? 28'(-gz0 + 32'sd4) : 28'(gz0);
      gz_prod = 56'(gz_mag) * DIV5_K29;
      gz_div = (gz0 < 0) ? -32'(gz_prod[55:29]) : 32'(gz_prod[55:29]);
      in_z = gz_ff >= 0 && gz_ff < Z_LIM;
      in_grid = in_z && gx_ff >= 0 && gy_ff >= 0 && gx_ff < XY_LIM && gy_ff < XY_LIM;
      zc = gz_ff >>> STEP_FRAC;
      inten_sub = (zc < GRID_Z) ? inten_ff - $signed({16'd0, rd_data}) : inten_ff;
      sum9 = {1'b0, rd_data} + {1'b0, byte_ff};
      ax = gx_ff - ((gx_ff < 0) ? -XY_LIM : ((gx_ff >= XY_LIM) ? XY_LIM : 32'sd0));
      ay = gy_ff - ((gy_ff < 0) ? -XY_LIM : ((gy_ff >= XY_LIM) ? XY_LIM : 32'sd0));
      ez5 = 36'(gz_ff) * 36'sd5;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      byte_in = byte_ff;
      addr_in = addr_ff;
      gx_in = gx_ff; gy_in = gy_ff; gz_in = gz_ff;
      inten_in = inten_ff;
      steps_in = steps_ff;
      rv_in = rv_ff && rsp_stall;
      ri_in = ri_ff; rs_in = rs_ff; ndx_in = ndx_ff; ndy_in = ndy_ff;
      ex_in = ex_ff; ey_in = ey_ff; ez_in = ez_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = 8'd0;
      rd_addr = addr_ff;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == AW'(CELLS - 1)) state_in = S_IDLE;
            else clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_BEGIN: begin
                     bx_in = 16'(tx * 2) + 16'(req_offset_x);
                     by_in = 16'(ty * 2) + 16'(req_offset_y);
                     bz_in = bz_div + 16'(req_offset_z);
                     dx_in = req_extent_x; dy_in = req_extent_y; dz_in = req_extent_z;
                     cx_in = '0; cy_in = '0; cz_in = '0;
                  end
                  CMD_RASTER: begin
                     if (dx_ff != 0 && dy_ff != 0 && dz_ff != 0 && cx_ff < dx_ff) begin
                        if (req_value[7:0] != 0 && nx >= 0 && ny >= 0 && nz >= 0 &&
                            nx < GRID_XY && ny < GRID_XY && nz < GRID_Z) begin
                           addr_in = AW'(nx) + AW'(ny) * AW'(GRID_XY)
                                   + AW'(nz) * AW'(GRID_XY * GRID_XY);
                           byte_in = req_value[7:0];
                           state_in = S_RMW_RD;
                        end
                        if (cz_ff + 1'b1 >= dz_ff) begin
                           cz_in = '0;
                           if (cy_ff + 1'b1 >= dy_ff) begin
                              cy_in = '0;
                              cx_in = cx_ff + 1'b1;
                           end else cy_in = cy_ff + 1'b1;
                        end else cz_in = cz_ff + 1'b1;
                     end
                  end
                  CMD_RAY: begin
                     gx_in = 32'(req_pos_x) <<< (UP + 1);
                     gy_in = 32'(req_pos_y) <<< (UP + 1);
                     gz_in = gz_div;
                     inten_in = 24'(req_value);
                     steps_in = '0;
                     state_in = S_RAY_CHK;
                  end
                  default: ;
               endcase
            end
         end
         S_RMW_RD: state_in = S_RMW_WR;
         S_RMW_WR: begin
            wr_en = 1'b1;
            wr_data = sum9[8] ? 8'hff : sum9[7:0];
            state_in = S_IDLE;
         end
         S_RAY_CHK: begin
            if (!in_grid || steps_ff >= SW'(MAX_STEPS)) state_in = S_DONE;
            else begin
               addr_in = AW'(gx_ff >>> STEP_FRAC) + AW'(gy_ff >>> STEP_FRAC) * AW'(GRID_XY)
                       + AW'(zc) * AW'(GRID_XY * GRID_XY);
               state_in = S_RAY_RD;
            end
         end
         S_RAY_RD: state_in = S_RAY_SUB;
         S_RAY_SUB: begin
            inten_in = inten_sub;
            if (inten_sub < 0) begin
               state_in = S_DONE;
            end else begin
               gx_in = gx_ff + 32'(stx_ff);
               gy_in = gy_ff + 32'(sty_ff);
               gz_in = gz_ff + 32'(stz_ff);
               steps_in = steps_ff + 1'b1;
               state_in = S_RAY_CHK;
            end
         end
         S_DONE: begin
            rv_in = 1'b1;
            ri_in = sat16(40'(inten_ff));
            ndx_in = '0; ndy_in = '0; ex_in = '0; ey_in = '0; ez_in = '0;
            if (!in_z) rs_in = ST_VERTICAL;
            else if (inten_ff <= 0 || in_grid) rs_in = ST_ABSORBED;
            else begin
               rs_in = ST_NEIGHBOUR;
               ndx_in = (gx_ff < 0) ? -2'sd1 : ((gx_ff >= XY_LIM) ? 2'sd1 : 2'sd0);
               ndy_in = (gy_ff < 0) ? -2'sd1 : ((gy_ff >= XY_LIM) ? 2'sd1 : 2'sd0);
               ex_in = sat16(40'(ax >>> (UP + 1)));
               ey_in = sat16(40'(ay >>> (UP + 1)));
               ez_in = sat16(40'(ez5 >>> UP) - (40'sd128 <<< FRAC_BITS));
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         stx_ff <= '0; sty_ff <= '0; stz_ff <= 16'sd16384;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
         dx_ff <= '0; dy_ff <= '0; dz_ff <= '0;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
         dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_STEP_X: stx_ff <= csr_data;
               CSR_STEP_Y: sty_ff <= csr_data;
               CSR_STEP_Z: stz_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in; addr_ff <= addr_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gz_ff <= gz_in;
      inten_ff <= inten_in; steps_ff <= steps_in;
      ri_ff <= ri_in; rs_ff <= rs_in; ndx_ff <= ndx_in; ndy_ff <= ndy_in;
      ex_ff <= ex_in; ey_ff <= ey_in; ez_ff <= ez_in;
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept) else $error("request taken while busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_DONE) else $error("stray result");
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW_RD) |=> (state_ff == S_RMW_WR)) else $error("rmw broken");
   a_clear_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall) else $error("request during clear");
`endif
endmodule
`default_nettype wire

// ===== rtl/vsrm_ram.sv =====
`default_nettype none
module vsrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== tb/voxel_shadow_ray_march_tb.sv =====
`timescale 1ns / 100ps
module voxel_shadow_ray_march_tb
   import vsrm_pkg::*;
();

   localparam int GXY = 16;
   localparam int GZ = 52;
   localparam int ZLIM = 45;
   localparam int FB = 8;
   localparam int SF = 14;
   localparam int MAX_STEPS = 2 * (2 * GXY + ZLIM);
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic signed [15:0] intensity_left;
      logic [1:0]         status;
      logic signed [1:0]  neighbour_dx;
      logic signed [1:0]  neighbour_dy;
      logic signed [15:0] exit_x;
      logic signed [15:0] exit_y;
      logic signed [15:0] exit_z;
   } shadow_type;

   typedef struct {
      cmd_type            cmd;
      logic signed [15:0] pos_x, pos_y, pos_z;
      logic signed [6:0]  off_x, off_y, off_z;
      logic [6:0]         ext_x, ext_y, ext_z;
      logic signed [15:0] value;
   } request_type;

   class shadow_scoreboard;
      byte unsigned grid[GXY * GXY * GZ];
      longint base_x, base_y, base_z;
      int dim_x, dim_y, dim_z, cnt_x, cnt_y, cnt_z;
      logic signed [15:0] dir_x, dir_y, dir_z;
      shadow_type pending[$];
      int errors;

      function void clear();
         foreach (grid[i]) grid[i] = 0;
         base_x = 0; base_y = 0; base_z = 0;
         dim_x = 0; dim_y = 0; dim_z = 0;
         cnt_x = 0; cnt_y = 0; cnt_z = 0;
         dir_x = 0; dir_y = 0; dir_z = 16384;
         errors = 0;
      endfunction

      function longint fdiv5(longint v);
         if (v >= 0) return v / 5;
         return -((-v + 4) / 5);
      endfunction

      function logic signed [15:0] clip16(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      function void set_dir(csr_type idx, logic [15:0] d);
         case (idx)
            CSR_STEP_X: dir_x = d;
            CSR_STEP_Y: dir_y = d;
            CSR_STEP_Z: dir_z = d;
            default: ;
         endcase
      endfunction

      function shadow_type march(request_type r);
         shadow_type o;
         longint gx, gy, gz, inten, cz, ndx, ndy;
         int steps;
         bit ins;
         gx = longint'(r.pos_x) * 2 * 64;
         gy = longint'(r.pos_y) * 2 * 64;
         gz = fdiv5((longint'(r.pos_z) + (128 << FB)) * 64);
         inten = longint'(r.value);
         steps = 0;
         ndx = 0; ndy = 0;
         o = '0;
         forever begin
            ins = gx >= 0 && gy >= 0 && gz >= 0 && gx < (GXY << SF) &&
                  gy < (GXY << SF) && gz < (longint'(ZLIM) << SF);
            if (!ins || steps >= MAX_STEPS) break;
            cz = gz >>> SF;
            if (cz < GZ)
               inten -= longint'(grid[(gx >>> SF) + (gy >>> SF) * GXY + cz * GXY * GXY]);
            if (inten < 0) break;
            gx += longint'(dir_x); gy += longint'(dir_y); gz += longint'(dir_z);
            steps++;
         end
         if (gz < 0 || gz >= (longint'(ZLIM) << SF)) o.status = ST_VERTICAL;
         else if (inten <= 0 || ins) o.status = ST_ABSORBED;
         else begin
            o.status = ST_NEIGHBOUR;
            if (gx < 0) ndx = -1;
            if (gx >= (GXY << SF)) ndx = 1;
            if (gy < 0) ndy = -1;
            if (gy >= (GXY << SF)) ndy = 1;
            o.neighbour_dx = ndx[1:0];
            o.neighbour_dy = ndy[1:0];
            o.exit_x = clip16((gx - ndx * (GXY << SF)) >>> (SF - FB + 1));
            o.exit_y = clip16((gy - ndy * (GXY << SF)) >>> (SF - FB + 1));
            o.exit_z = clip16(((gz * 5) >>> (SF - FB)) - (128 << FB));
         end
         o.intensity_left = clip16(inten);
         return o;
      endfunction

      function void note_request(request_type r);
         longint nx, ny, nz, idx, s;
         case (r.cmd)
            CMD_BEGIN: begin
               base_x = (longint'(r.pos_x) >>> FB) * 2 + longint'(r.off_x);
               base_y = (longint'(r.pos_y) >>> FB) * 2 + longint'(r.off_y);
               base_z = (((longint'(r.pos_z) >>> FB) + 128) * 2) / 10 + longint'(r.off_z);
               dim_x = int'(r.ext_x); dim_y = int'(r.ext_y); dim_z = int'(r.ext_z);
               cnt_x = 0; cnt_y = 0; cnt_z = 0;
            end
            CMD_RASTER: begin
               if (dim_x != 0 && dim_y != 0 && dim_z != 0 && cnt_x < dim_x) begin
                  nx = base_x + longint'(cnt_x);
                  ny = base_y + longint'(cnt_y);
                  nz = base_z + longint'(cnt_z);
                  if (r.value[7:0] != 0 && nx >= 0 && ny >= 0 && nz >= 0 &&
                      nx < GXY && ny < GXY && nz < GZ) begin
                     idx = nx + ny * GXY + nz * GXY * GXY;
                     s = longint'(grid[idx]) + longint'(r.value[7:0]);
                     grid[idx] = (s > 255) ? 8'd255 : 8'(s);
                  end
                  if (++cnt_z >= dim_z) begin
                     cnt_z = 0;
                     if (++cnt_y >= dim_y) begin
                        cnt_y = 0;
                        cnt_x++;
                     end
                  end
               end
            end
            CMD_RAY: pending.push_back(march(r));
            default: ;
         endcase
      endfunction

      function void check_result(shadow_type got);
         shadow_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.intensity_left !== want.intensity_left) begin
            $display("%0t intensity_left exp %0d got %0d", $time,
                     want.intensity_left, got.intensity_left);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t status exp %0d got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.neighbour_dx !== want.neighbour_dx) begin
            $display("%0t neighbour_dx exp %0d got %0d", $time,
                     want.neighbour_dx, got.neighbour_dx);
            errors++;
         end
         if (got.neighbour_dy !== want.neighbour_dy) begin
            $display("%0t neighbour_dy exp %0d got %0d", $time,
                     want.neighbour_dy, got.neighbour_dy);
            errors++;
         end
         if (got.exit_x !== want.exit_x) begin
            $display("%0t exit_x exp %0d got %0d", $time, want.exit_x, got.exit_x);
            errors++;
         end
         if (got.exit_y !== want.exit_y) begin
            $display("%0t exit_y exp %0d got %0d", $time, want.exit_y, got.exit_y);
            errors++;
         end
         if (got.exit_z !== want.exit_z) begin
            $display("%0t exit_z exp %0d got %0d", $time, want.exit_z, got.exit_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = 0;
   logic signed [15:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0, req_value = 0;
   logic signed [6:0] req_offset_x = 0, req_offset_y = 0, req_offset_z = 0;
   logic [6:0] req_extent_x = 0, req_extent_y = 0, req_extent_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_intensity_left, rsp_exit_x, rsp_exit_y, rsp_exit_z;
   logic [1:0] rsp_status;
   logic signed [1:0] rsp_neighbour_dx, rsp_neighbour_dy;
   logic csr_write = 0;
   logic [1:0] csr_index = 0;
   logic [15:0] csr_data = 0;

   shadow_scoreboard board;
   longint cycles = 0;
   bit calm = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   voxel_shadow_ray_march dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_intensity_left, rsp_status, rsp_neighbour_dx,
                             rsp_neighbour_dy, rsp_exit_x, rsp_exit_y, rsp_exit_z});
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 13);

   task automatic send(request_type r);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_cmd <= r.cmd;
      req_pos_x <= r.pos_x; req_pos_y <= r.pos_y; req_pos_z <= r.pos_z;
      req_offset_x <= r.off_x; req_offset_y <= r.off_y; req_offset_z <= r.off_z;
      req_extent_x <= r.ext_x; req_extent_y <= r.ext_y; req_extent_z <= r.ext_z;
      req_value <= r.value;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (800) @(negedge clock);
   endtask

   task automatic set_light(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
      csr_write <= 1;
      csr_index <= CSR_STEP_X; csr_data <= dx;
      @(negedge clock);
      csr_index <= CSR_STEP_Y; csr_data <= dy;
      @(negedge clock);
      csr_index <= CSR_STEP_Z; csr_data <= dz;
      @(negedge clock);
      csr_write <= 0;
      board.set_dir(CSR_STEP_X, dx);
      board.set_dir(CSR_STEP_Y, dy);
      board.set_dir(CSR_STEP_Z, dz);
   endtask

   function automatic request_type blank(cmd_type c);
      request_type r;
      r.cmd = c;
      r.pos_x = 0; r.pos_y = 0; r.pos_z = 0;
      r.off_x = 0; r.off_y = 0; r.off_z = 0;
      r.ext_x = 0; r.ext_y = 0; r.ext_z = 0;
      r.value = 0;
      return r;
   endfunction

   function automatic request_type ray(int range_xy);
      request_type r;
      r = blank(CMD_RAY);
      r.pos_x = 16'($urandom_range(range_xy));
      r.pos_y = 16'($urandom_range(range_xy));
      r.pos_z = 16'($urandom_range(32767) - 32768 + $urandom_range(32767));
      r.value = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3000));
      return r;
   endfunction

   function automatic request_type noise();
      request_type r;
      r.cmd = cmd_type'($urandom_range(3));
      r.pos_x = 16'($urandom); r.pos_y = 16'($urandom); r.pos_z = 16'($urandom);
      r.off_x = 7'($urandom); r.off_y = 7'($urandom); r.off_z = 7'($urandom);
      r.ext_x = 7'($urandom); r.ext_y = 7'($urandom); r.ext_z = 7'($urandom);
      r.value = 16'($urandom);
      return r;
   endfunction

   task automatic place_model();
      request_type r;
      int n;
      r = blank(CMD_BEGIN);
      r.pos_x = 16'($urandom_range(2047) - 256);
      r.pos_y = 16'($urandom_range(2047) - 256);
      r.pos_z = 16'($urandom);
      r.off_x = 7'($urandom_range(8) - 4);
      r.off_y = 7'($urandom_range(8) - 4);
      r.off_z = 7'($urandom_range(30) - 10);
      r.ext_x = 7'($urandom_range(1, 3));
      r.ext_y = 7'($urandom_range(1, 3));
      r.ext_z = 7'($urandom_range(1, 4));
      send(r);
      n = int'(r.ext_x) * int'(r.ext_y) * int'(r.ext_z) + int'($urandom_range(2));
      repeat (n) begin
         r = blank(CMD_RASTER);
         r.value = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
         if ($urandom_range(5) == 0) r.value = 0;
         send(r);
      end
   endtask

   function automatic logic [15:0] unit_comp();
      int pick;
      pick = int'($urandom_range(5));
      case (pick)
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 0;
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   initial begin
      request_type r;
      board = new();
      board.clear();
      repeat (8) @(negedge clock);
      reset <= 0;

      // directed: fill a column, edge positions, every command
      r = blank(CMD_BEGIN);
      r.pos_x = 16'sh0200; r.pos_y = 16'sh0300; r.pos_z = 16'sh8000;
      r.ext_x = 1; r.ext_y = 1; r.ext_z = 64;
      send(r);
      for (int i = 0; i < 6; i++) begin
         r = blank(CMD_RASTER);
         r.value = (i == 1) ? 16'sh0000 : (i == 2 ? 16'sh7fff : 16'sh00c8);
         send(r);
      end
      r = blank(CMD_NONE); r.value = 16'sh7fff; send(r);
      r = blank(CMD_RAY); r.pos_x = 16'sh0200; r.pos_y = 16'sh0300;
      r.pos_z = 16'sh8000; r.value = 16'sh7fff; send(r);
      r.value = 16'sh0064; send(r);
      r.value = 16'sh8000; send(r);
      r.pos_x = 16'sh7fff; r.value = 100; send(r);
      r.pos_x = -1; send(r);
      r.pos_x = 16'sh0100; r.pos_z = 16'sh7fff; send(r);
      drain();
      set_light(16'sd16384, 0, 0);
      r.pos_x = 16'sh0700; r.pos_z = 0; r.value = 500; send(r);
      r.pos_x = 0; send(r);
      drain();
      set_light(-16'sd16384, -16'sd16384, -16'sd16384);
      r.pos_x = 16'sh0100; r.pos_y = 16'sh0100; r.pos_z = 16'sh7fff; send(r);
      r.pos_z = 16'sh1000; send(r);
      drain();
      set_light(0, 0, 0);
      r.pos_z = 0; r.value = 1; send(r);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         calm = (phase == 3);
         set_light(unit_comp(), unit_comp(), unit_comp());
         for (int k = 0; k < 33; k++) begin
            case ($urandom_range(9))
               0, 1: place_model();
               2: send(noise());
               3: send(ray(16'hffff));
               default: send(ray(16'h0800));
            endcase
         end
         drain();
      end
      calm = 0;

      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== voxel_shadow_ray_march.f =====
rtl/vsrm_pkg.sv
rtl/vsrm_ram.sv
rtl/voxel_shadow_ray_march.sv
tb/voxel_shadow_ray_march_tb.sv
